// ===== rtl/itoa_pkg.sv =====
// Shared types, constants and character helpers for the integer to ASCII formatter.
package itoa_pkg;

  localparam int RADIX_MIN = 2;
  localparam int RADIX_MAX = 36;
  localparam int DEC_RADIX = 10;
  localparam int OUT_LIMIT = 64;
  localparam int DIV_BITS  = 8;

  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_X     = 7'h78;
  localparam logic [6:0] CHAR_A     = 7'h61;

  typedef struct packed {
    logic [63:0] value;
    logic        signed_mode;
    logic [5:0]  radix;
    logic [5:0]  pad_width;
    logic        zero_pad;
    logic        hex_prefix;
  } itoa_in_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       last_char;
  } itoa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_SIGN,
    ST_PFX0,
    ST_PFXX,
    ST_PAD,
    ST_DIG
  } itoa_state_t;

  typedef enum logic [2:0] {
    KIND_SIGN,
    KIND_ZERO,
    KIND_X,
    KIND_PAD,
    KIND_DIG
  } itoa_kind_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       prep;
    logic       emit;
    itoa_kind_t kind;
  } itoa_cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic digit_end;
    logic quo_zero;
    logic neg;
    logic pfx_ok;
    logic pad_any;
    logic pad_last;
    logic dig_last;
    logic out_free;
  } itoa_stat_t;

  function automatic logic [6:0] digit_char(input logic [5:0] d);
    if (d < 6'(DEC_RADIX)) begin
      digit_char = CHAR_ZERO + 7'(d);
    end else begin
      digit_char = CHAR_A + 7'(d) - 7'(DEC_RADIX);
    end
  endfunction

endpackage

// ===== rtl/itoa_ctrl.sv =====
// Sequencer for division, setup and character emission of one request.
module itoa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  itoa_pkg::itoa_stat_t stat,
  output itoa_pkg::itoa_cmd_t  cmd
);
  import itoa_pkg::*;

  itoa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid && stat.radix_ok) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.digit_end && stat.quo_zero) state_next = ST_PREP;
      end
      ST_PREP: begin
        if (stat.neg) state_next = ST_SIGN;
        else if (stat.pfx_ok) state_next = ST_PFX0;
        else if (stat.pad_any) state_next = ST_PAD;
        else state_next = ST_DIG;
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          if (stat.pfx_ok) state_next = ST_PFX0;
          else if (stat.pad_any) state_next = ST_PAD;
          else state_next = ST_DIG;
        end
      end
      ST_PFX0: begin
        if (stat.out_free) state_next = ST_PFXX;
      end
      ST_PFXX: begin
        if (stat.out_free) state_next = stat.pad_any ? ST_PAD : ST_DIG;
      end
      ST_PAD: begin
        if (stat.out_free && stat.pad_last) state_next = ST_DIG;
      end
      ST_DIG: begin
        if (stat.out_free && stat.dig_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.kind  = KIND_DIG;
    req_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid && stat.radix_ok;
      end
      ST_DIV:  cmd.step = 1'b1;
      ST_PREP: cmd.prep = 1'b1;
      ST_SIGN: begin
        cmd.emit = stat.out_free;
        cmd.kind = KIND_SIGN;
      end
      ST_PFX0: begin
        cmd.emit = stat.out_free;
        cmd.kind = KIND_ZERO;
      end
      ST_PFXX: begin
        cmd.emit = stat.out_free;
        cmd.kind = KIND_X;
      end
      ST_PAD: begin
        cmd.emit = stat.out_free;
        cmd.kind = KIND_PAD;
      end
      ST_DIG: begin
        cmd.emit = stat.out_free;
        cmd.kind = KIND_DIG;
      end
      default: req_stall = 1'b1;
    endcase
  end

endmodule

// ===== rtl/itoa_dp.sv =====
// Datapath: radix divider, digit memory, pad and digit counters and output register.
module itoa_dp #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_PAD     = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  itoa_pkg::itoa_in_t   req,
  output logic                 chr_valid,
  input  logic                 chr_stall,
  output itoa_pkg::itoa_out_t  chr,
  input  itoa_pkg::itoa_cmd_t  cmd,
  output itoa_pkg::itoa_stat_t stat
);
  import itoa_pkg::*;

  localparam int DW    = ((VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int NSTEP = DW / DIV_BITS;
  localparam int SCW   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int AW    = $clog2(VALUE_WIDTH);
  localparam int NW    = $clog2(VALUE_WIDTH + 1);

  logic [DW-1:0]          quo;
  logic [5:0]             rem;
  logic [SCW-1:0]         step_cnt;
  logic [NW-1:0]          ndig;
  logic [5:0]             radix_r;
  logic [5:0]             pad_r;
  logic                   neg_r;
  logic                   zpad_r;
  logic                   pfx_r;
  logic [5:0]             padidx;
  logic [AW-1:0]          rdptr;
  logic [AW-1:0]          rdptr_next;
  logic [5:0]             rd_digit;
  logic [5:0]             dmem [VALUE_WIDTH];

  logic [VALUE_WIDTH-1:0] v_in;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [5:0]             pad_in;
  logic [DW-1:0]          div_q;
  logic [5:0]             div_r;
  logic [6:0]             div_t;
  logic [5:0]             padcount;
  logic [7:0]             total;
  logic [6:0]             chr_char;

  assign v_in   = req.value[VALUE_WIDTH-1:0];
  assign neg_in = req.signed_mode && (req.radix == 6'(DEC_RADIX)) && v_in[VALUE_WIDTH-1];
  assign mag_in = neg_in ? (~v_in + 1'b1) : v_in;
  assign pad_in = (req.pad_width > 6'(MAX_PAD)) ? 6'(MAX_PAD) : req.pad_width;

  always_comb begin
    div_r = rem;
    div_q = quo;
    div_t = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      div_t = {div_r, div_q[DW-1]};
      div_q = {div_q[DW-2:0], 1'b0};
      if (div_t >= {1'b0, radix_r}) begin
        div_r    = 6'(div_t - {1'b0, radix_r});
        div_q[0] = 1'b1;
      end else begin
        div_r = div_t[5:0];
      end
    end
  end

  assign padcount = (zpad_r && (8'(pad_r) > 8'(ndig))) ? 6'(8'(pad_r) - 8'(ndig)) : 6'd0;
  assign total    = 8'(neg_r) + 8'(padcount) + 8'(ndig);

  always_comb begin
    stat.radix_ok  = (req.radix >= 6'(RADIX_MIN)) && (req.radix <= 6'(RADIX_MAX));
    stat.digit_end = (step_cnt == SCW'(NSTEP - 1));
    stat.quo_zero  = (div_q == '0);
    stat.neg       = neg_r;
    stat.pfx_ok    = pfx_r && (total <= 8'(OUT_LIMIT - 2));
    stat.pad_any   = (padcount != 6'd0);
    stat.pad_last  = ((padidx + 6'd1) == padcount);
    stat.dig_last  = (rdptr == '0);
    stat.out_free  = !chr_valid || !chr_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo      <= DW'(mag_in);
      rem      <= '0;
      step_cnt <= '0;
      ndig     <= '0;
      radix_r  <= req.radix;
      pad_r    <= pad_in;
      neg_r    <= neg_in;
      zpad_r   <= req.zero_pad;
      pfx_r    <= req.hex_prefix;
    end else if (cmd.step) begin
      quo <= div_q;
      if (stat.digit_end) begin
        rem              <= '0;
        step_cnt         <= '0;
        dmem[ndig[AW-1:0]] <= div_r;
        ndig             <= ndig + 1'b1;
      end else begin
        rem      <= div_r;
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    rdptr_next = rdptr;
    if (cmd.prep) begin
      rdptr_next = AW'(ndig - 1'b1);
    end else if (cmd.emit && (cmd.kind == KIND_DIG) && (rdptr != '0)) begin
      rdptr_next = rdptr - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdptr    <= rdptr_next;
    rd_digit <= dmem[rdptr_next];
    if (cmd.prep) begin
      padidx <= '0;
    end else if (cmd.emit && (cmd.kind == KIND_PAD) && stat.pad_any) begin
      padidx <= padidx + 6'd1;
    end
  end

  always_comb begin
    case (cmd.kind)
      KIND_SIGN: chr_char = CHAR_MINUS;
      KIND_ZERO: chr_char = CHAR_ZERO;
      KIND_X:    chr_char = CHAR_X;
      KIND_PAD:  chr_char = CHAR_ZERO;
      KIND_DIG:  chr_char = digit_char(rd_digit);
      default:   chr_char = CHAR_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (cmd.emit) begin
      chr_valid <= 1'b1;
    end else if (!chr_stall) begin
      chr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      chr.ascii_char <= chr_char;
      chr.last_char  <= (cmd.kind == KIND_DIG) && (rdptr == '0);
    end
  end

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: controller and datapath.
// Each request is converted by a divider that retires 8 quotient bits per cycle; each digit
// is the remainder left after one pass of the divider over the whole quotient. The largest
// 64-bit value in radix ten has 20 digits. Characters leave one per cycle from a registered
// output while the output is not stalled, most significant first, with last_char on the
// final digit. A request whose radix lies outside 2 to 36 is taken and dropped with no
// characters. A new request is taken as soon as the last character of the previous one
// sits in the output register.
module integer_to_ascii_formatter #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_PAD     = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  itoa_pkg::itoa_in_t  req,
  output logic                chr_valid,
  input  logic                chr_stall,
  output itoa_pkg::itoa_out_t chr
);
  import itoa_pkg::*;

  itoa_cmd_t  cmd;
  itoa_stat_t stat;

  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  itoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_PAD     (MAX_PAD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
